// ===== hw/rtl/adp_pkg.sv =====
// adp_pkg: shared types and constants for the ARM data-processing execute block.
// No dependencies; every other file in hw/rtl refers to it by scoped names.

package adp_pkg;

    localparam int WORD_W     = 32;
    localparam int REG_ADDR_W = 4;
    localparam int REG_DEPTH  = 1 << REG_ADDR_W;
    localparam int SHAMT_W    = 8;   // register-specified amount: low byte of Rs

    localparam logic [REG_ADDR_W-1:0] REG_PC   = 4'hF;
    localparam logic [7:0]            IMM_MASK = 8'hFF;

    // Read ports of the two register-file copies: Rn and Rm, then Rs
    localparam int RF_A_PORTS = 2;
    localparam int RF_B_PORTS = 1;

    // Output tdata layout, lowest bit first
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 1;

    typedef enum logic [3:0] {
        OP_AND = 4'h0, OP_EOR = 4'h1, OP_SUB = 4'h2, OP_RSB = 4'h3,
        OP_ADD = 4'h4, OP_ADC = 4'h5, OP_SBC = 4'h6, OP_RSC = 4'h7,
        OP_TST = 4'h8, OP_TEQ = 4'h9, OP_CMP = 4'hA, OP_CMN = 4'hB,
        OP_ORR = 4'hC, OP_MOV = 4'hD, OP_BIC = 4'hE, OP_MVN = 4'hF
    } t_opcode_e;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift_e;

    // Status flags, N in the top bit
    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    // Decoded control fields handed to the ALU
    typedef struct packed {
        t_opcode_e             opcode;
        logic                  s_bit;
        logic [REG_ADDR_W-1:0] rd;
    } t_decode;

    function automatic logic [WORD_W-1:0] ror32(input logic [WORD_W-1:0] v,
                                                input logic [4:0]        n);
        logic [2*WORD_W-1:0] dbl;
        dbl = {v, v} >> n;
        return dbl[WORD_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/adp_regfile.sv =====
// adp_regfile: 16 x 32 register file, one write port, RD_PORTS registered read ports.
// Write-through on a same-cycle write; entries read as zero until first written.
// Depends on adp_pkg.

module adp_regfile #(
    parameter int RD_PORTS = adp_pkg::RF_A_PORTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [adp_pkg::REG_ADDR_W-1:0] i_waddr,
    input  logic [adp_pkg::WORD_W-1:0]     i_wdata,
    input  logic                           i_re,
    input  logic [adp_pkg::REG_ADDR_W-1:0] i_raddr [RD_PORTS],
    output logic [adp_pkg::WORD_W-1:0]     o_rdata [RD_PORTS]
);

    logic [adp_pkg::WORD_W-1:0]    r_mem [adp_pkg::REG_DEPTH];
    logic [adp_pkg::REG_DEPTH-1:0] r_valid;
    logic [adp_pkg::WORD_W-1:0]    r_rdata [RD_PORTS];
    logic [adp_pkg::WORD_W-1:0]    n_rdata [RD_PORTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Valid bits stand in for the reset clear of the array
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_comb begin
        for (int p = 0; p < RD_PORTS; p++) begin
            if (i_we && (i_waddr == i_raddr[p])) begin
                n_rdata[p] = i_wdata;
            end else if (r_valid[i_raddr[p]]) begin
                n_rdata[p] = r_mem[i_raddr[p]];
            end else begin
                n_rdata[p] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= n_rdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/adp_shifter.sv =====
// adp_shifter: operand-2 barrel shifter (rotated immediate or shifted register).
// Produces operand 2 and the shifter carry-out. Depends on adp_pkg.

module adp_shifter (
    input  logic [adp_pkg::WORD_W-1:0] i_instr,
    input  logic [adp_pkg::WORD_W-1:0] i_rm,
    input  logic [adp_pkg::WORD_W-1:0] i_rs,
    input  logic                       i_cin,
    output logic [adp_pkg::WORD_W-1:0] o_op2,
    output logic                       o_cout
);

    localparam int W = adp_pkg::WORD_W;

    adp_pkg::t_shift_e                 sh_type;
    logic [4:0]                        imm_amt;
    logic [4:0]                        rot;
    logic [adp_pkg::SHAMT_W-1:0]       amt;
    logic [adp_pkg::WORD_W-1:0]        imm_val;
    logic [2*W-1:0]                    lsl_t;
    logic [2*W-1:0]                    lsr_t;
    logic signed [2*W-1:0]             asr_t;
    logic [adp_pkg::WORD_W-1:0]        ror_t;

    assign sh_type = adp_pkg::t_shift_e'(i_instr[6:5]);
    assign imm_amt = i_instr[11:7];
    assign rot     = {i_instr[11:8], 1'b0};
    assign imm_val = adp_pkg::ror32({24'd0, i_instr[7:0] & adp_pkg::IMM_MASK}, rot);

    // Register form: amount from Rs low byte, else the 5-bit field (0 means 32 for LSR/ASR)
    always_comb begin
        if (i_instr[4]) begin
            amt = i_rs[adp_pkg::SHAMT_W-1:0];
        end else if (imm_amt == 5'd0) begin
            amt = 8'd32;
        end else begin
            amt = {3'd0, imm_amt};
        end
    end

    assign lsl_t = {{W{1'b0}}, i_rm} << amt[4:0];
    assign lsr_t = {i_rm, {W{1'b0}}} >> amt[4:0];
    assign asr_t = $signed({i_rm, {W{1'b0}}}) >>> amt[4:0];
    assign ror_t = adp_pkg::ror32(i_rm, amt[4:0]);

    always_comb begin
        o_op2  = i_rm;
        o_cout = i_cin;
        if (i_instr[25]) begin
            o_op2  = imm_val;
            o_cout = (rot == 5'd0) ? i_cin : imm_val[W-1];
        end else if (i_instr[4] && (amt == '0)) begin
            o_op2  = i_rm;
            o_cout = i_cin;
        end else if (!i_instr[4] && (imm_amt == 5'd0) && (sh_type == adp_pkg::SH_LSL)) begin
            o_op2  = i_rm;
            o_cout = i_cin;
        end else if (!i_instr[4] && (imm_amt == 5'd0) && (sh_type == adp_pkg::SH_ROR)) begin
            // RRX
            o_op2  = {i_cin, i_rm[W-1:1]};
            o_cout = i_rm[0];
        end else begin
            case (sh_type)
                adp_pkg::SH_LSL: begin
                    if (amt < 8'd32) begin
                        o_op2  = lsl_t[W-1:0];
                        o_cout = lsl_t[W];
                    end else if (amt == 8'd32) begin
                        o_op2  = '0;
                        o_cout = i_rm[0];
                    end else begin
                        o_op2  = '0;
                        o_cout = 1'b0;
                    end
                end
                adp_pkg::SH_LSR: begin
                    if (amt < 8'd32) begin
                        o_op2  = lsr_t[2*W-1:W];
                        o_cout = lsr_t[W-1];
                    end else if (amt == 8'd32) begin
                        o_op2  = '0;
                        o_cout = i_rm[W-1];
                    end else begin
                        o_op2  = '0;
                        o_cout = 1'b0;
                    end
                end
                adp_pkg::SH_ASR: begin
                    if (amt < 8'd32) begin
                        o_op2  = asr_t[2*W-1:W];
                        o_cout = asr_t[W-1];
                    end else begin
                        o_op2  = {W{i_rm[W-1]}};
                        o_cout = i_rm[W-1];
                    end
                end
                adp_pkg::SH_ROR: begin
                    o_op2  = ror_t;
                    o_cout = ror_t[W-1];
                end
                default: begin
                    o_op2  = i_rm;
                    o_cout = i_cin;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/adp_alu.sv =====
// adp_alu: the sixteen data-processing operations and the N Z C V update.
// One shared 33-bit adder serves all arithmetic opcodes. Depends on adp_pkg.

module adp_alu (
    input  adp_pkg::t_decode           i_dec,
    input  logic [adp_pkg::WORD_W-1:0] i_op1,
    input  logic [adp_pkg::WORD_W-1:0] i_op2,
    input  logic                       i_sh_cout,
    input  adp_pkg::t_flags            i_flags,
    output logic [adp_pkg::WORD_W-1:0] o_result,
    output logic                       o_writes,
    output adp_pkg::t_flags            o_flags
);

    localparam int W = adp_pkg::WORD_W;

    logic [W-1:0] add_a;
    logic [W-1:0] add_b;
    logic         add_c;
    logic [W:0]   sum;
    logic         ovf;
    logic         arith;
    logic         setf;

    always_comb begin
        add_a    = i_op1;
        add_b    = i_op2;
        add_c    = 1'b0;
        arith    = 1'b1;
        o_result = '0;
        case (i_dec.opcode)
            adp_pkg::OP_AND, adp_pkg::OP_TST: begin
                arith = 1'b0;
            end
            adp_pkg::OP_EOR, adp_pkg::OP_TEQ: begin
                arith = 1'b0;
            end
            adp_pkg::OP_SUB, adp_pkg::OP_CMP: begin
                add_b = ~i_op2;
                add_c = 1'b1;
            end
            adp_pkg::OP_RSB: begin
                add_a = i_op2;
                add_b = ~i_op1;
                add_c = 1'b1;
            end
            adp_pkg::OP_ADD, adp_pkg::OP_CMN: begin
                add_c = 1'b0;
            end
            adp_pkg::OP_ADC: begin
                add_c = i_flags.c;
            end
            adp_pkg::OP_SBC: begin
                add_b = ~i_op2;
                add_c = i_flags.c;
            end
            adp_pkg::OP_RSC: begin
                add_a = i_op2;
                add_b = ~i_op1;
                add_c = i_flags.c;
            end
            default: begin
                arith = 1'b0;
            end
        endcase

        sum = {1'b0, add_a} + {1'b0, add_b} + {{W{1'b0}}, add_c};
        ovf = ~(add_a[W-1] ^ add_b[W-1]) & (add_a[W-1] ^ sum[W-1]);

        case (i_dec.opcode)
            adp_pkg::OP_AND, adp_pkg::OP_TST: o_result = i_op1 & i_op2;
            adp_pkg::OP_EOR, adp_pkg::OP_TEQ: o_result = i_op1 ^ i_op2;
            adp_pkg::OP_ORR:                  o_result = i_op1 | i_op2;
            adp_pkg::OP_MOV:                  o_result = i_op2;
            adp_pkg::OP_BIC:                  o_result = i_op1 & ~i_op2;
            adp_pkg::OP_MVN:                  o_result = ~i_op2;
            default:                          o_result = sum[W-1:0];
        endcase
    end

    assign o_writes = !(i_dec.opcode inside {adp_pkg::OP_TST, adp_pkg::OP_TEQ,
                                              adp_pkg::OP_CMP, adp_pkg::OP_CMN});
    // Writes to the PC with S set leave the flags alone
    assign setf = !o_writes || (i_dec.s_bit && (i_dec.rd != adp_pkg::REG_PC));

    always_comb begin
        o_flags = i_flags;
        if (setf) begin
            o_flags.n = o_result[W-1];
            o_flags.z = (o_result == '0);
            o_flags.c = arith ? sum[W] : i_sh_cout;
            o_flags.v = arith ? ovf : i_flags.v;
        end
    end

endmodule

// ===== hw/rtl/arm_data_processing_alu.sv =====
// arm_data_processing_alu: top level of the ARMv4 data-processing execute block.
// Instantiates adp_regfile (two copies), adp_shifter and adp_alu; uses adp_pkg.
//
// Usage
//   Slave channel: one 32-bit data-processing instruction word per transfer
//   (condition field ignored, every word executes). Master channel: one result
//   per instruction, carrying Rd, the ALU result and the flags after it, with
//   tuser flagging whether Rd was written.
//   Pipeline: input register (instruction word plus registered register-file
//   reads of Rn, Rm and Rs) -> shifter and ALU -> result register.
//   o_m_axis_tvalid rises after the input and result registers; throughput is
//   one instruction per cycle unless the receiver stalls (single execute stage).
//   Register-file and flag results of one instruction are seen by the very
//   next one: the register file writes through to reads taken in the same
//   cycle, and the flags live in the execute stage.
//   Reset (synchronous, active low) empties both stages, clears the flags and
//   makes all sixteen registers read as zero.
//   While the receiver stalls, the result register holds its transfer and the
//   input register still takes one more instruction; after that
//   o_s_axis_tready falls until the master side drains.

module arm_data_processing_alu (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [adp_pkg::WORD_W-1:0]     i_s_axis_tdata,   // [31:0] instr_word
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [3:0] dest_index, [35:4] result_value, [36] flag_n, [37] flag_z,
    // [38] flag_c, [39] flag_v
    output logic [adp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [adp_pkg::OUT_USER_W-1:0] o_m_axis_tuser    // [0] writes_dest
);

    localparam int W  = adp_pkg::WORD_W;
    localparam int AW = adp_pkg::REG_ADDR_W;

    // Execute stage
    logic             r_ex_valid;
    logic [W-1:0]     r_instr;
    adp_pkg::t_flags  r_flags;

    // Result register
    logic                           r_out_valid;
    logic [adp_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [adp_pkg::OUT_USER_W-1:0] r_out_user;

    logic             s_fire;
    logic             ex_fire;
    logic [AW-1:0]    rf_a_addr [adp_pkg::RF_A_PORTS];
    logic [W-1:0]     rf_a_data [adp_pkg::RF_A_PORTS];
    logic [AW-1:0]    rf_b_addr [adp_pkg::RF_B_PORTS];
    logic [W-1:0]     rf_b_data [adp_pkg::RF_B_PORTS];
    logic             rf_we;

    adp_pkg::t_decode dec;
    logic [W-1:0]     op2;
    logic             sh_cout;
    logic [W-1:0]     result;
    logic             writes;
    adp_pkg::t_flags  n_flags;

    // Execute advances whenever the result register is free or being drained
    assign ex_fire         = r_ex_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_ex_valid || ex_fire;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    // Read addresses come straight off the incoming word: Rn, Rm and Rs
    assign rf_a_addr[0] = i_s_axis_tdata[19:16];
    assign rf_a_addr[1] = i_s_axis_tdata[3:0];
    assign rf_b_addr[0] = i_s_axis_tdata[11:8];

    assign rf_we = ex_fire && writes;

    // Two identical copies, written together, give the three read ports
    adp_regfile #(
        .RD_PORTS (adp_pkg::RF_A_PORTS)
    ) u_rf_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (rf_we),
        .i_waddr (dec.rd),
        .i_wdata (result),
        .i_re    (s_fire),
        .i_raddr (rf_a_addr),
        .o_rdata (rf_a_data)
    );

    adp_regfile #(
        .RD_PORTS (adp_pkg::RF_B_PORTS)
    ) u_rf_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (rf_we),
        .i_waddr (dec.rd),
        .i_wdata (result),
        .i_re    (s_fire),
        .i_raddr (rf_b_addr),
        .o_rdata (rf_b_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_ex_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_instr <= i_s_axis_tdata;
        end
    end

    assign dec.opcode = adp_pkg::t_opcode_e'(r_instr[24:21]);
    assign dec.s_bit  = r_instr[20];
    assign dec.rd     = r_instr[15:12];

    adp_shifter u_shifter (
        .i_instr (r_instr),
        .i_rm    (rf_a_data[1]),
        .i_rs    (rf_b_data[0]),
        .i_cin   (r_flags.c),
        .o_op2   (op2),
        .o_cout  (sh_cout)
    );

    adp_alu u_alu (
        .i_dec     (dec),
        .i_op1     (rf_a_data[0]),
        .i_op2     (op2),
        .i_sh_cout (sh_cout),
        .i_flags   (r_flags),
        .o_result  (result),
        .o_writes  (writes),
        .o_flags   (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (ex_fire) begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ex_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ex_fire) begin
            r_out_data <= {n_flags.v, n_flags.c, n_flags.z, n_flags.n, result, dec.rd};
            r_out_user <= writes;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

// ===== hw/rtl/adp_checker.sv =====
// adp_checker: port-level assertions for arm_data_processing_alu, bound to the top.
// Sees the top-level ports only. Depends on adp_pkg.

module adp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    input  logic                           o_s_axis_tready,
    input  logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic [adp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic [adp_pkg::OUT_USER_W-1:0] o_m_axis_tuser
);

    // Instructions accepted and not yet delivered
    logic [1:0] r_count;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_xfer && !out_xfer) begin
            r_count <= r_count + 2'd1;
        end else if (out_xfer && !in_xfer) begin
            r_count <= r_count - 2'd1;
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // Compare and test opcodes always set N and Z from the result
    a_test_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |->
            (o_m_axis_tdata[37] == (o_m_axis_tdata[35:4] == '0)) &&
            (o_m_axis_tdata[36] == o_m_axis_tdata[35]))
        else $error("flags of a compare do not match its result");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_count != 2'd0))
        else $error("result without an accepted instruction");

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("more instructions in flight than pipeline stages");

endmodule

bind arm_data_processing_alu adp_checker u_adp_checker (.*);

// ===== bench/testbench.sv =====
// testbench: self-checking bench for arm_data_processing_alu (ARMv4 data-processing stage).
// Depends on adp_pkg and the RTL under hw/rtl; predicts every result with its own copy
// of the register file and flags and checks the master stream against it.

module testbench;
    import adp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int          RANDOM_ITEMS = 450;
    localparam int          HOLD_CYCLES  = 80;   // long receiver hold-off, fills the pipe
    localparam int          TAIL_CYCLES  = 10;   // settle time after the last transfer

    // One expected master-side transfer
    typedef struct {
        logic [3:0]  rd;
        logic [31:0] value;
        logic        wr;
        t_flags      flags;
    } t_dp_result;

    // Scoreboard: shadow register file and flags, queue of pending results
    class dp_scoreboard;
        logic [31:0] regs [16];
        t_flags      flags;
        t_dp_result  expected_q [$];
        int          errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            flags  = '0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [31:0] rotr(logic [31:0] v, int unsigned n);
            n = n % 32;
            return (n == 0) ? v : ((v >> n) | (v << (32 - n)));
        endfunction

        // Operand 2 and the shifter carry-out
        function logic [31:0] operand2(logic [31:0] w, logic cin, output logic cout);
            logic [31:0] rm, res;
            t_shift_e    kind;
            int unsigned amt, rot;
            if (w[25]) begin
                rot  = {w[11:8], 1'b0};
                res  = rotr({24'd0, w[7:0]}, rot);
                cout = (rot == 0) ? cin : res[31];
                return res;
            end
            rm   = regs[w[3:0]];
            kind = t_shift_e'(w[6:5]);
            if (w[4]) begin
                amt = regs[w[11:8]][7:0];
                if (amt == 0) begin
                    cout = cin;
                    return rm;
                end
            end else begin
                amt = w[11:7];
                if (amt == 0) begin
                    case (kind)
                        SH_LSL: begin
                            cout = cin;
                            return rm;
                        end
                        SH_ROR: begin   // RRX
                            cout = rm[0];
                            return {cin, rm[31:1]};
                        end
                        default: amt = 32;   // LSR/ASR #0 mean #32
                    endcase
                end
            end
            case (kind)
                SH_LSL: begin
                    if (amt < 32) begin
                        cout = rm[32 - amt];
                        res  = rm << amt;
                    end else begin
                        cout = (amt == 32) ? rm[0] : 1'b0;
                        res  = '0;
                    end
                end
                SH_LSR: begin
                    if (amt < 32) begin
                        cout = rm[amt - 1];
                        res  = rm >> amt;
                    end else begin
                        cout = (amt == 32) ? rm[31] : 1'b0;
                        res  = '0;
                    end
                end
                SH_ASR: begin
                    if (amt < 32) begin
                        cout = rm[amt - 1];
                        res  = $signed(rm) >>> amt;
                    end else begin
                        cout = rm[31];
                        res  = {32{rm[31]}};
                    end
                end
                default: begin
                    res  = rotr(rm, amt);
                    cout = res[31];
                end
            endcase
            return res;
        endfunction

        function logic [31:0] add_carry(logic [31:0] a, logic [31:0] b, logic ci,
                                        output logic co, output logic ov);
            logic [32:0] sum;
            sum = {1'b0, a} + {1'b0, b} + {32'd0, ci};
            co  = sum[32];
            ov  = (a[31] == b[31]) && (sum[31] != a[31]);
            return sum[31:0];
        endfunction

        // Executes one accepted instruction on the shadow state, queues its result
        function void log_instruction(logic [31:0] w);
            t_opcode_e   op;
            logic [31:0] op1, op2, res;
            logic        cin, sc, c, v, logical, writes, setf;
            logic [3:0]  rd;
            t_dp_result  item;
            op      = t_opcode_e'(w[24:21]);
            rd      = w[15:12];
            cin     = flags.c;
            c       = cin;
            v       = flags.v;
            logical = 1'b0;
            op1     = regs[w[19:16]];
            op2     = operand2(w, cin, sc);
            case (op)
                OP_AND, OP_TST: begin res = op1 & op2; logical = 1'b1; end
                OP_EOR, OP_TEQ: begin res = op1 ^ op2; logical = 1'b1; end
                OP_SUB, OP_CMP: res = add_carry(op1, ~op2, 1'b1, c, v);
                OP_RSB:         res = add_carry(op2, ~op1, 1'b1, c, v);
                OP_ADD, OP_CMN: res = add_carry(op1, op2, 1'b0, c, v);
                OP_ADC:         res = add_carry(op1, op2, cin, c, v);
                OP_SBC:         res = add_carry(op1, ~op2, cin, c, v);
                OP_RSC:         res = add_carry(op2, ~op1, cin, c, v);
                OP_ORR:         begin res = op1 | op2;  logical = 1'b1; end
                OP_MOV:         begin res = op2;        logical = 1'b1; end
                OP_BIC:         begin res = op1 & ~op2; logical = 1'b1; end
                default:        begin res = ~op2;       logical = 1'b1; end
            endcase
            if (logical) c = sc;
            case (op)
                OP_TST, OP_TEQ, OP_CMP, OP_CMN: writes = 1'b0;
                default:                        writes = 1'b1;
            endcase
            setf = !writes || (w[20] && rd != REG_PC);
            if (writes) regs[rd] = res;
            if (setf) flags = {res[31], res == 32'd0, c, v};
            item.rd    = rd;
            item.value = res;
            item.wr    = writes;
            item.flags = flags;
            expected_q.push_back(item);
        endfunction

        function void compare_field(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
            t_dp_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h/%h",
                         $time, data, user);
                return;
            end
            want = expected_q.pop_front();
            compare_field("dest_index",   32'(want.rd),      32'(data[3:0]));
            compare_field("result_value", want.value,        data[35:4]);
            compare_field("flag_n",       32'(want.flags.n), 32'(data[36]));
            compare_field("flag_z",       32'(want.flags.z), 32'(data[37]));
            compare_field("flag_c",       32'(want.flags.c), 32'(data[38]));
            compare_field("flag_v",       32'(want.flags.v), 32'(data[39]));
            compare_field("writes_dest",  32'(want.wr),      32'(user[0]));
        endfunction
    endclass

    // Clock, reset and DUT ports; every input known from time zero
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [WORD_W-1:0]     i_s_axis_tdata  = '0;  // [31:0] instr_word
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // [3:0] dest_index, [35:4] result_value, [36] flag_n, [37] flag_z,
    // [38] flag_c, [39] flag_v
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [OUT_USER_W-1:0] o_m_axis_tuser;          // [0] writes_dest

    // Knobs shared by the stimulus, the receiver and the watchdog
    bit          tx_idle_on  = 1'b1;
    bit          rx_idle_on  = 1'b1;
    bit          rx_hold_req = 1'b0;
    int unsigned cycle_count = 0;

    dp_scoreboard board;

    arm_data_processing_alu uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result monitor: samples pre-edge values, so it never races the DUT registers
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_result(o_m_axis_tdata, o_m_axis_tuser);
    end

    // Receiver: random stall bursts, plus one long hold-off on request so the
    // result register and the input register both fill and tready drops
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0 && rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall_left  = HOLD_CYCLES;
            end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 18);
            end
            if (stall_left != 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Instruction encoders; condition field fixed to AL, random words override it
    function automatic logic [31:0] dp_word(t_opcode_e op, logic s, logic [3:0] rn,
                                            logic [3:0] rd, logic imm, logic [11:0] op2);
        return {4'hE, 2'b00, imm, op, s, rn, rd, op2};
    endfunction

    function automatic logic [11:0] sh_imm(logic [4:0] amt, t_shift_e kind, logic [3:0] rm);
        return {amt, kind, 1'b0, rm};
    endfunction

    function automatic logic [11:0] sh_reg(logic [3:0] rs, t_shift_e kind, logic [3:0] rm);
        return {rs, 1'b0, kind, 1'b1, rm};
    endfunction

    // Mostly well-formed words with edge-biased amounts; some register loads of
    // shift-amount corner values; the rest fully random words
    function automatic logic [31:0] random_word();
        int unsigned pick;
        logic [31:0] w;
        logic [7:0]  imm8;
        logic [4:0]  amt;
        logic [11:0] op2;
        t_shift_e    kind;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return $urandom();
        if (pick < 35) begin
            case ($urandom_range(0, 5))
                0:       imm8 = 8'd0;
                1:       imm8 = 8'd32;
                2:       imm8 = 8'd33;
                3:       imm8 = IMM_MASK;
                default: imm8 = 8'($urandom());
            endcase
            op2 = {($urandom_range(0, 2) == 0) ? 4'($urandom()) : 4'd0, imm8};
            w   = dp_word($urandom_range(0, 3) == 0 ? OP_MVN : OP_MOV, 1'($urandom()),
                          4'($urandom()), 4'($urandom()), 1'b1, op2);
        end else begin
            kind = t_shift_e'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0:       amt = 5'd0;
                1:       amt = 5'd31;
                default: amt = 5'($urandom());
            endcase
            pick = $urandom_range(0, 3);
            if (pick == 0)
                op2 = 12'($urandom());
            else if (pick == 1)
                op2 = sh_reg(4'($urandom()), kind, 4'($urandom()));
            else
                op2 = sh_imm(amt, kind, 4'($urandom()));
            w = dp_word(t_opcode_e'($urandom_range(0, 15)), 1'($urandom()),
                        4'($urandom()), 4'($urandom()), pick == 0, op2);
        end
        w[31:28] = 4'($urandom());
        return w;
    endfunction

    // One slave transfer; valid stays high if the caller sends again right away
    task automatic send_instr(input logic [31:0] word);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        board.log_instruction(word);
    endtask

    task automatic send_item(input logic [31:0] word);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        send_instr(word);
    endtask

    // Drop valid and wait until every queued result has come back
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // Directed part: register loads, every opcode, every shift corner
    task automatic run_directed();
        send_item(dp_word(OP_MOV, 1'b1, 4'd0, 4'd0, 1'b1, {4'd0, IMM_MASK}));  // rot 0 keeps C
        send_item(dp_word(OP_MOV, 1'b1, 4'd0, 4'd1, 1'b1, {4'd1, 8'h02}));    // 0x80000000
        send_item(dp_word(OP_MVN, 1'b0, 4'd0, 4'd2, 1'b1, 12'd0));            // all ones
        send_item(dp_word(OP_MOV, 1'b0, 4'd0, 4'd3, 1'b1, {4'd0, 8'd32}));
        send_item(dp_word(OP_MOV, 1'b0, 4'd0, 4'd4, 1'b1, {4'd0, 8'd33}));
        send_item(dp_word(OP_AND, 1'b1, 4'd2, 4'd6, 1'b0, sh_imm(5'd4, SH_LSL, 4'd0)));
        send_item(dp_word(OP_EOR, 1'b1, 4'd1, 4'd7, 1'b0, sh_imm(5'd0, SH_LSR, 4'd2)));
        send_item(dp_word(OP_SUB, 1'b1, 4'd0, 4'd8, 1'b0, sh_imm(5'd0, SH_ASR, 4'd1)));
        send_item(dp_word(OP_RSB, 1'b1, 4'd0, 4'd9, 1'b0, sh_imm(5'd0, SH_ROR, 4'd2)));
        send_item(dp_word(OP_ADD, 1'b1, 4'd2, 4'd10, 1'b0, sh_imm(5'd0, SH_LSL, 4'd0)));
        send_item(dp_word(OP_ADC, 1'b1, 4'd1, 4'd11, 1'b0, sh_imm(5'd0, SH_LSL, 4'd1)));
        send_item(dp_word(OP_SBC, 1'b1, 4'd0, 4'd12, 1'b0, sh_reg(4'd3, SH_LSL, 4'd2)));
        send_item(dp_word(OP_RSC, 1'b1, 4'd1, 4'd13, 1'b0, sh_reg(4'd4, SH_LSR, 4'd2)));
        send_item(dp_word(OP_TST, 1'b0, 4'd2, 4'd5, 1'b0, sh_reg(4'd3, SH_ASR, 4'd1)));
        send_item(dp_word(OP_TEQ, 1'b0, 4'd0, 4'd0, 1'b0, sh_reg(4'd4, SH_ROR, 4'd2)));
        send_item(dp_word(OP_CMP, 1'b0, 4'd1, 4'd0, 1'b0, sh_imm(5'd0, SH_LSL, 4'd0)));
        send_item(dp_word(OP_CMN, 1'b0, 4'd2, 4'd0, 1'b1, {4'd0, 8'd1}));
        send_item(dp_word(OP_ORR, 1'b1, 4'd0, REG_PC, 1'b0, sh_imm(5'd0, SH_LSL, 4'd1)));
        send_item(dp_word(OP_MOV, 1'b1, 4'd0, 4'd14, 1'b0, sh_reg(4'd5, SH_LSL, 4'd0)));
        send_item(dp_word(OP_BIC, 1'b1, 4'd2, 4'd6, 1'b0, sh_imm(5'd8, SH_ROR, 4'd0)));
        send_item(dp_word(OP_MVN, 1'b1, 4'd0, 4'd7, 1'b0, sh_imm(5'd0, SH_LSL, 4'd2)));
        send_item(dp_word(OP_MOV, 1'b1, 4'd0, 4'd8, 1'b0, sh_reg(4'd0, SH_LSL, 4'd2)));
        send_item(dp_word(OP_ADD, 1'b0, REG_PC, REG_PC, 1'b1, {4'd0, 8'd4}));
        send_item(32'h0000_0000);
        send_item(32'hFFFF_FFFF);
    endtask

    // Main sequence
    initial begin
        board = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 120)
                rx_hold_req = 1'b1;          // long hold-off while the sender keeps going
            if (i == 200) begin
                tx_idle_on = 1'b0;           // back-to-back stretch
                rx_idle_on = 1'b0;
            end
            if (i == 250) begin
                tx_idle_on = 1'b1;
                rx_idle_on = 1'b1;
            end
            if (i == 300)
                drain();                     // sender pause until all results are in
            if (i == 370) begin
                tx_idle_on = 1'b0;           // no idling in the final part
                rx_idle_on = 1'b0;
            end
            send_item(random_word());
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
